FILE: hdl/path_decimate_heading_defines.svh
// Assertion macros for the checker file of this block.
`ifndef PATH_DECIMATE_HEADING_DEFINES_SVH
`define PATH_DECIMATE_HEADING_DEFINES_SVH

// Implication checked in the same cycle.
`define PDH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define PDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pdh_pkg.sv
package pdh_pkg;

  localparam int COORD_FRAC_BITS  = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int ATAN_IDX_W       = $clog2(ATAN_ENTRIES);

  localparam int COORD_W    = 24;
  localparam int TIME_W     = 24;
  localparam int QUAT_W     = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SQ_W       = PROD_W;
  localparam int ANGLE_FRAC = 30;
  localparam int XY_W       = DIFF_W + ANGLE_FRAC + 3;
  localparam int ANG_W      = 35;
  localparam int ATAN_W     = 30;

  localparam logic [COORD_W-1:0] THR_RESET =
      COORD_W'(((64'd1 << COORD_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [ANG_W-1:0] PI_Q30   = ANG_W'(64'd3373259426);
  localparam logic signed [XY_W-1:0]  GAIN_Q30 = XY_W'(64'd652032874);

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [TIME_W-1:0]         point_time;
    logic                      path_first;
    logic                      path_last;
  } pdh_in_t;

  typedef struct packed {
    logic                      pose_valid;
    logic signed [COORD_W-1:0] pose_x;
    logic signed [COORD_W-1:0] pose_y;
    logic [TIME_W-1:0]         pose_time;
    logic signed [QUAT_W-1:0]  quat_z;
    logic signed [QUAT_W-1:0]  quat_w;
    logic                      path_end;
  } pdh_out_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } pdh_start_t;

  typedef struct packed {
    logic done;
    logic keep;
  } pdh_dist_sts_t;

  typedef struct packed {
    logic                     done;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
  } pdh_quat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIST,
    ST_CORDIC,
    ST_EMIT
  } pdh_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_VEC,
    PH_ROT
  } pdh_phase_e;

  typedef enum logic [2:0] {
    DS_IDLE,
    DS_DXX,
    DS_DYY,
    DS_THR,
    DS_CMP
  } pdh_dstep_e;

  // Arctangent of 2^-i in radians times 2^30, truncated.
  function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd843314856;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043836;
      5'd3:    v = 30'd133525158;
      5'd4:    v = 30'd67021686;
      5'd5:    v = 30'd33543515;
      5'd6:    v = 30'd16775850;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194282;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048575;
      5'd11:   v = 30'd524287;
      5'd12:   v = 30'd262143;
      5'd13:   v = 30'd131071;
      5'd14:   v = 30'd65535;
      5'd15:   v = 30'd32767;
      5'd16:   v = 30'd16383;
      5'd17:   v = 30'd8191;
      5'd18:   v = 30'd4095;
      5'd19:   v = 30'd2047;
      5'd20:   v = 30'd1023;
      5'd21:   v = 30'd511;
      5'd22:   v = 30'd255;
      5'd23:   v = 30'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/path_decimate_heading.sv
// Path point decimator with heading quaternion.
// Raw points enter on the in channel (valid/ready), one at a time. A point that is
// farther than the threshold from the pending kept point causes one pose on the out
// channel: the pending point with the yaw quaternion of the heading toward the new
// point. A point marked last always causes a result carrying the path end flag.
// The threshold register is written over the cfg channel, which is always ready;
// write it only while no item is in flight.
// Per item: a path start is dropped in ST_IDLE, with an end marker from ST_EMIT
// if it is also last; any other point goes through the distance test, and a kept
// point then through the CORDIC unit, which runs the vectoring and then the
// rotation pass one step per cycle, before ST_EMIT.
// The distance test uses one multiplier three times, in steps DXX, DYY, THR, then CMP.
// in_ready_o is high only between items. A finished result sits in the output
// register, so the next item is taken while the receiver stalls; an item with a
// result then waits in ST_EMIT until the register is free, and so do those behind it.
// Reset clears the pending point to the origin at time 0 and loads the default
// threshold of 0.1 m.
module path_decimate_heading #(
  parameter int CORDIC_STEPS = pdh_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pdh_pkg::COORD_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pdh_pkg::pdh_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pdh_pkg::pdh_out_t           out_data_o
);
  import pdh_pkg::*;

  pdh_state_e                state_q, state_d;
  logic signed [COORD_W-1:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic [TIME_W-1:0]         pend_t_q, pend_t_d;
  logic [COORD_W-1:0]        thr_q;
  logic signed [DIFF_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  pdh_in_t                   in_q, in_d;
  logic                      keep_q, keep_d;
  logic                      out_valid_q, out_valid_d;
  pdh_out_t                  out_q, out_d;
  pdh_start_t                dist_ctrl, cordic_ctrl;
  pdh_dist_sts_t             dist_sts;
  pdh_quat_t                 cordic_sts;

  pdh_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dist_ctrl),
    .thr_i  (thr_q),
    .sts_o  (dist_sts)
  );

  pdh_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cordic_ctrl),
    .sts_o  (cordic_sts)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    pend_x_d    = pend_x_q;
    pend_y_d    = pend_y_q;
    pend_t_d    = pend_t_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    in_d        = in_q;
    keep_d      = keep_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    dist_ctrl   = '{start: 1'b0, dx: dx_q, dy: dy_q};
    cordic_ctrl = '{start: 1'b0, dx: dx_q, dy: dy_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_d = in_data_i;
          if (in_data_i.path_first) begin
            pend_x_d = '0;
            pend_y_d = '0;
            pend_t_d = '0;
            keep_d   = 1'b0;
            if (in_data_i.path_last) begin
              state_d = ST_EMIT;
            end
          end else begin
            dx_d            = DIFF_W'($signed(in_data_i.point_x)) - DIFF_W'(pend_x_q);
            dy_d            = DIFF_W'($signed(in_data_i.point_y)) - DIFF_W'(pend_y_q);
            dist_ctrl.start = 1'b1;
            state_d         = ST_DIST;
          end
        end
      end
      ST_DIST: begin
        if (dist_sts.done) begin
          keep_d = dist_sts.keep;
          if (dist_sts.keep) begin
            cordic_ctrl.start = 1'b1;
            state_d           = ST_CORDIC;
          end else if (in_q.path_last) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CORDIC: begin
        if (cordic_sts.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Wait for the output register to drain before loading the result.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.pose_valid = keep_q;
          out_d.pose_x     = keep_q ? pend_x_q : '0;
          out_d.pose_y     = keep_q ? pend_y_q : '0;
          out_d.pose_time  = keep_q ? pend_t_q : '0;
          out_d.quat_z     = keep_q ? cordic_sts.quat_z : '0;
          out_d.quat_w     = keep_q ? cordic_sts.quat_w : '0;
          out_d.path_end   = in_q.path_last;
          if (keep_q) begin
            pend_x_d = in_q.point_x;
            pend_y_d = in_q.point_y;
            pend_t_d = in_q.point_time;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_x_q    <= '0;
      pend_y_q    <= '0;
      pend_t_q    <= '0;
      thr_q       <= THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_x_q    <= pend_x_d;
      pend_y_q    <= pend_y_d;
      pend_t_q    <= pend_t_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    in_q   <= in_d;
    keep_q <= keep_d;
    out_q  <= out_d;
  end

endmodule

FILE: hdl/pdh_dist.sv
module pdh_dist (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pdh_pkg::pdh_start_t          ctrl_i,
  input  logic [pdh_pkg::COORD_W-1:0]  thr_i,
  output pdh_pkg::pdh_dist_sts_t       sts_o
);
  import pdh_pkg::*;

  pdh_dstep_e               step_q, step_d;
  logic signed [DIFF_W-1:0] op_a, op_b, thr_s;
  logic signed [PROD_W-1:0] prod;
  logic [SQ_W-1:0]          prod_q, prod_d, acc_q, acc_d;

  assign thr_s = $signed({1'b0, thr_i});
  assign prod  = op_a * op_b;

  // One multiplier, used for dx*dx, dy*dy and the squared threshold in turn.
  always_comb begin
    op_a   = ctrl_i.dx;
    op_b   = ctrl_i.dx;
    step_d = step_q;
    prod_d = prod_q;
    acc_d  = acc_q;
    sts_o  = '0;
    case (step_q)
      DS_IDLE: begin
        if (ctrl_i.start) begin
          step_d = DS_DXX;
        end
      end
      DS_DXX: begin
        prod_d = $unsigned(prod);
        step_d = DS_DYY;
      end
      DS_DYY: begin
        op_a   = ctrl_i.dy;
        op_b   = ctrl_i.dy;
        acc_d  = prod_q;
        prod_d = $unsigned(prod);
        step_d = DS_THR;
      end
      DS_THR: begin
        op_a   = thr_s;
        op_b   = thr_s;
        acc_d  = acc_q + prod_q;
        prod_d = $unsigned(prod);
        step_d = DS_CMP;
      end
      DS_CMP: begin
        sts_o.done = 1'b1;
        sts_o.keep = acc_q > prod_q;
        step_d     = DS_IDLE;
      end
      default: step_d = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= DS_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

endmodule

FILE: hdl/pdh_cordic.sv
module pdh_cordic #(
  parameter int CORDIC_STEPS = pdh_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdh_pkg::pdh_start_t ctrl_i,
  output pdh_pkg::pdh_quat_t  sts_o
);
  import pdh_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int STEP_W = $clog2(NSTEPS);
  localparam logic [STEP_W-1:0]      LAST_STEP = STEP_W'(NSTEPS - 1);
  localparam logic signed [XY_W-1:0] ROUND_Q15 = XY_W'(16384);
  localparam logic signed [XY_W-1:0] Q15_MAX   = XY_W'(32767);
  localparam logic signed [XY_W-1:0] Q15_MIN   = -XY_W'(32768);

  pdh_phase_e               phase_q, phase_d;
  logic signed [XY_W-1:0]   x_q, x_d, y_q, y_d;
  logic signed [XY_W-1:0]   xs, ys, x_step, y_step, dx_ext, dy_ext;
  logic signed [ANG_W-1:0]  ang_q, ang_d, atan_v, ang_step;
  logic [STEP_W-1:0]        i_q, i_d;
  logic                     turn_pos;
  logic                     last_step;
  logic                     done;

  function automatic logic signed [QUAT_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] r;
    r = (v + ROUND_Q15) >>> 15;
    if (r > Q15_MAX) begin
      r = Q15_MAX;
    end else if (r < Q15_MIN) begin
      r = Q15_MIN;
    end
    return r[QUAT_W-1:0];
  endfunction

  assign dx_ext = XY_W'($signed(ctrl_i.dx));
  assign dy_ext = XY_W'($signed(ctrl_i.dy));
  assign atan_v = $signed(ANG_W'(atan_q30(ATAN_IDX_W'(i_q))));
  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;

  // Vectoring drives y toward zero; rotation drives the residual angle toward zero.
  // Both use the same add/subtract unit, only the direction decision differs.
  assign turn_pos  = (phase_q == PH_ROT) ? !ang_q[ANG_W-1]
                                         : (y_q[XY_W-1] || (y_q == '0));
  assign x_step    = turn_pos ? x_q - ys : x_q + ys;
  assign y_step    = turn_pos ? y_q + xs : y_q - xs;
  assign ang_step  = turn_pos ? ang_q - atan_v : ang_q + atan_v;
  assign last_step = (i_q == LAST_STEP);

  always_comb begin
    phase_d = phase_q;
    x_d     = x_q;
    y_d     = y_q;
    ang_d   = ang_q;
    i_d     = i_q;
    done    = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (ctrl_i.start) begin
          // A vector in the left half plane is turned by a half circle first.
          if (ctrl_i.dx[DIFF_W-1]) begin
            x_d   = (-dx_ext) <<< ANGLE_FRAC;
            y_d   = (-dy_ext) <<< ANGLE_FRAC;
            ang_d = ctrl_i.dy[DIFF_W-1] ? -PI_Q30 : PI_Q30;
          end else begin
            x_d   = dx_ext <<< ANGLE_FRAC;
            y_d   = dy_ext <<< ANGLE_FRAC;
            ang_d = '0;
          end
          i_d     = '0;
          phase_d = PH_VEC;
        end
      end
      PH_VEC: begin
        x_d   = x_step;
        y_d   = y_step;
        ang_d = ang_step;
        i_d   = i_q + STEP_W'(1);
        if (last_step) begin
          ang_d   = ang_step >>> 1;
          x_d     = GAIN_Q30;
          y_d     = '0;
          i_d     = '0;
          phase_d = PH_ROT;
        end
      end
      PH_ROT: begin
        x_d   = x_step;
        y_d   = y_step;
        ang_d = ang_step;
        i_d   = i_q + STEP_W'(1);
        if (last_step) begin
          i_d     = '0;
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // x and y hold cos and sin of the half heading until the next start.
  assign sts_o.done   = done;
  assign sts_o.quat_z = to_q15(y_q);
  assign sts_o.quat_w = to_q15(x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    ang_q <= ang_d;
    i_q   <= i_d;
  end

endmodule

FILE: hdl/pdh_checker.sv
`include "path_decimate_heading_defines.svh"

module pdh_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input pdh_pkg::pdh_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pdh_pkg::pdh_out_t out_data_o
);
  import pdh_pkg::*;

  // A stalled result keeps its contents until the transfer.
  `PDH_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result changed while stalled")

  // A result without a pose is only ever an end marker with all fields cleared.
  `PDH_ASSERT_NOW(a_marker_form, out_valid_o && !out_data_o.pose_valid, out_data_o.path_end && out_data_o.pose_x == '0 && out_data_o.pose_y == '0 && out_data_o.pose_time == '0 && out_data_o.quat_z == '0 && out_data_o.quat_w == '0, "malformed end marker")

  // A point that is not a path start always needs the distance unit.
  `PDH_ASSERT_NEXT(a_busy_after_point, in_valid_i && in_ready_o && !in_data_i.path_first, !in_ready_o, "ready right after a point transfer")

  // The threshold register takes a write in any cycle.
  `PDH_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o, "configuration write refused")

endmodule

bind path_decimate_heading pdh_checker u_pdh_checker (.*);

FILE: sim/tb_path_decimate_heading.sv
module tb_path_decimate_heading;
  import pdh_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;
  localparam longint PI_ANG = 64'sd3373259426;
  localparam longint GAIN_START = 64'sd652032874;
  localparam int SETTLE = 2 * NSTEPS + 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_POINTS = 250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COORD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  pdh_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pdh_out_t out_data;

  // Mirror of the block's threshold and pending kept point.
  logic [COORD_W-1:0] step_thr = THR_RESET;
  longint trk_x = 0;
  longint trk_y = 0;
  longint trk_time = 0;

  pdh_out_t pose_q[$];
  pdh_out_t exp_pose;
  longint atan_tbl [0:23] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  int errors = 0;
  int n_points = 0;
  int n_poses = 0;
  int n_markers = 0;
  int n_settings = 0;
  int idle_count = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  bit hold_req = 1'b0;

  path_decimate_heading u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Runs of back-to-back transfers alternate with runs of random gaps.
  function automatic int idle_cycles(inout bit burst);
    if ($urandom_range(0, 63) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic signed [QUAT_W-1:0] round_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return QUAT_W'(r);
  endfunction

  // Vectoring pass finds the heading, the rotation pass turns the gain
  // vector by half of it to give cos and sin of the half angle.
  function automatic void half_heading_quat(input longint dx, input longint dy,
                                            output logic signed [QUAT_W-1:0] qz,
                                            output logic signed [QUAT_W-1:0] qw);
    longint x, y, ang, nx, ny, c, s;
    int i;
    x = dx;
    y = dy;
    ang = 0;
    if (dx < 0) begin
      ang = (dy >= 0) ? PI_ANG : -PI_ANG;
      x = -dx;
      y = -dy;
    end
    x = x <<< 30;
    y = y <<< 30;
    for (i = 0; i < NSTEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        ang = ang + atan_tbl[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        ang = ang - atan_tbl[i];
      end
      x = nx;
      y = ny;
    end
    ang = ang >>> 1;
    c = GAIN_START;
    s = 0;
    for (i = 0; i < NSTEPS; i++) begin
      if (ang >= 0) begin
        nx = c - (s >>> i);
        ny = s + (c >>> i);
        ang = ang - atan_tbl[i];
      end else begin
        nx = c + (s >>> i);
        ny = s - (c >>> i);
        ang = ang + atan_tbl[i];
      end
      c = nx;
      s = ny;
    end
    qz = round_q15(s);
    qw = round_q15(c);
  endfunction

  function automatic void decimate_point(input pdh_in_t pt);
    longint dx, dy, d2, thr2;
    pdh_out_t res;
    bit emit;
    res = '0;
    emit = 1'b0;
    if (pt.path_first) begin
      trk_x = 0;
      trk_y = 0;
      trk_time = 0;
    end else begin
      dx = longint'(pt.point_x) - trk_x;
      dy = longint'(pt.point_y) - trk_y;
      d2 = dx * dx + dy * dy;
      thr2 = longint'(step_thr) * longint'(step_thr);
      if (d2 > thr2) begin
        res.pose_valid = 1'b1;
        res.pose_x = COORD_W'(trk_x);
        res.pose_y = COORD_W'(trk_y);
        res.pose_time = TIME_W'(trk_time);
        half_heading_quat(dx, dy, res.quat_z, res.quat_w);
        trk_x = longint'(pt.point_x);
        trk_y = longint'(pt.point_y);
        trk_time = longint'(pt.point_time);
        emit = 1'b1;
      end
    end
    if (pt.path_last) begin
      res.path_end = 1'b1;
      emit = 1'b1;
    end
    if (emit) pose_q = {pose_q, res};
  endfunction

  function automatic pdh_in_t mk_point(input longint x, input longint y, input longint t,
                                       input bit first, input bit last);
    pdh_in_t p;
    p.point_x = x[COORD_W-1:0];
    p.point_y = y[COORD_W-1:0];
    p.point_time = t[TIME_W-1:0];
    p.path_first = first;
    p.path_last = last;
    return p;
  endfunction

  function automatic pdh_in_t noise_point();
    return mk_point($urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Valid is lowered only ahead of a gap, so a back-to-back item never
  // sees valid dropped and raised in one step.
  task automatic send_point(input pdh_in_t pt);
    int gap;
    gap = idle_cycles(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pt;
    do @(posedge clk); while (!in_ready);
    decimate_point(pt);
    n_points++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
  endtask

  // A dropped point may still be in flight after the last result, so the
  // write waits out the longest item time as well.
  task automatic write_threshold(input logic [COORD_W-1:0] thr);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_thr = thr;
    n_settings++;
  endtask

  task automatic cmp_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        $error("unexpected result transfer: %h", out_data);
        errors++;
      end else begin
        exp_pose = pose_q.pop_front();
        cmp_field("pose_valid", exp_pose.pose_valid, out_data.pose_valid);
        cmp_field("pose_x", exp_pose.pose_x, out_data.pose_x);
        cmp_field("pose_y", exp_pose.pose_y, out_data.pose_y);
        cmp_field("pose_time", exp_pose.pose_time, out_data.pose_time);
        cmp_field("quat_z", exp_pose.quat_z, out_data.quat_z);
        cmp_field("quat_w", exp_pose.quat_w, out_data.quat_w);
        cmp_field("path_end", exp_pose.path_end, out_data.path_end);
        if (exp_pose.pose_valid) n_poses++;
        else n_markers++;
      end
    end
  end

  // Receiver: random stalls per transfer, plus one long hold on request.
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = idle_cycles(out_burst);
      if (hold_req) begin
        stall = stall + HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_count = 0;
      else
        idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed_cases();
    // Default threshold, pending at the origin with no path start seen.
    send_point(mk_point(6554, 0, 5, 0, 0));
    send_point(mk_point(6555, 0, 16, 0, 0));
    send_point(mk_point(-3445, 0, 32, 0, 0));
    send_point(mk_point(-3445, -20000, 48, 0, 0));
    send_point(mk_point(20000, -20000, 64, 0, 0));
    send_point(mk_point(8388607, 8388607, 24'hFFFFFF, 0, 0));
    send_point(mk_point(-8388608, -8388608, 0, 0, 0));
    send_point(mk_point(-8388608, 8388607, 24'h800000, 0, 1));
    // A last point that keeps nothing gives the end marker alone; pending
    // is not cleared, so the next point is measured from it.
    send_point(mk_point(-8388608, 8388607, 7, 0, 1));
    send_point(mk_point(-8388000, 8388607, 8, 0, 0));
    send_point(mk_point(12345, -777, 9, 1, 1));
    send_point(mk_point(100, -100000, 10, 0, 0));
    send_point(mk_point(-1, -1, 24'hFFFFFF, 1, 0));
    send_point(mk_point(-1, 1, 11, 0, 0));
    send_point(mk_point(-70000, 1, 12, 0, 0));
    send_point(mk_point(-70001, 1, 13, 0, 1));
  endtask

  task automatic test_threshold_extremes();
    write_threshold('0);
    send_point(mk_point(5, 5, 1, 1, 0));
    send_point(mk_point(0, 0, 2, 0, 0));
    send_point(mk_point(1, 0, 3, 0, 0));
    send_point(mk_point(1, 0, 4, 0, 0));
    send_point(mk_point(1, -1, 5, 0, 1));
    write_threshold('1);
    send_point(mk_point(0, 0, 1, 1, 0));
    send_point(mk_point(8388607, 0, 2, 0, 0));
    send_point(mk_point(-8388608, 8388607, 3, 0, 0));
    send_point(mk_point(-8388608, -8388608, 4, 0, 1));
    write_threshold(24'd1);
    send_point(mk_point(0, 0, 1, 1, 0));
    send_point(mk_point(1, 0, 2, 0, 0));
    send_point(mk_point(2, 1, 3, 0, 0));
    send_point(mk_point(1, 0, 4, 0, 1));
  endtask

  // Holding the receiver fills the output register and the item behind it,
  // so the input side must stall until the hold ends.
  task automatic test_output_stall();
    longint x, y;
    int k;
    write_threshold(THR_RESET);
    x = 0;
    y = 0;
    send_point(mk_point(0, 0, 0, 1, 0));
    hold_req = 1'b1;
    for (k = 0; k < 12; k++) begin
      x = clamp_coord(x + longint'($urandom_range(0, 200000)) - 100000);
      y = clamp_coord(y + longint'($urandom_range(0, 200000)) - 100000);
      send_point(mk_point(x, y, k * 100, 0, k == 11));
    end
  endtask

  task automatic test_drain_pause();
    int k;
    send_point(mk_point(0, 0, 0, 1, 0));
    for (k = 1; k <= 6; k++) send_point(mk_point(k * 40000, -k * 30000, k, 0, 0));
    wait_drained();
    for (k = 7; k <= 10; k++) send_point(mk_point(k * 40000, k * 9000, k, 0, k == 10));
  endtask

  task automatic test_random_paths();
    logic [COORD_W-1:0] thr_set [7];
    pdh_in_t pt;
    longint cx, cy, ct, span;
    int p, sent, len, k;
    thr_set[0] = THR_RESET;
    thr_set[1] = '0;
    thr_set[2] = '1;
    thr_set[3] = 24'd1;
    thr_set[4] = COORD_W'($urandom_range(2, 65535));
    thr_set[5] = COORD_W'($urandom);
    thr_set[6] = THR_RESET;
    for (p = 0; p < 7; p++) begin
      write_threshold(thr_set[p]);
      span = 2 * longint'(thr_set[p]) + 64;
      if (span > 64'd16777216) span = 64'd16777216;
      sent = 0;
      while (sent < PHASE_POINTS) begin
        pt = noise_point();
        pt.path_first = 1'b1;
        pt.path_last = ($urandom_range(0, 15) == 0);
        send_point(pt);
        sent++;
        if (pt.path_last) continue;
        cx = 0;
        cy = 0;
        ct = $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0) begin
          cx = longint'($signed(COORD_W'($urandom)));
          cy = longint'($signed(COORD_W'($urandom)));
        end
        len = $urandom_range(1, 24);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            pt = noise_point();
          end else begin
            // Axis-aligned steps now and then hit the heading boundaries.
            if ($urandom_range(0, 7) != 0)
              cx = clamp_coord(cx + longint'($urandom_range(0, 2 * span)) - span);
            if ($urandom_range(0, 7) != 0)
              cy = clamp_coord(cy + longint'($urandom_range(0, 2 * span)) - span);
            ct = ct + $urandom_range(1, 4096);
            pt = mk_point(cx, cy, ct, 0, k == len - 1);
          end
          send_point(pt);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_threshold_extremes();
    test_output_stall();
    test_drain_pause();
    test_random_paths();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d points under %0d threshold settings; checked %0d poses and %0d end markers,",
             n_points, n_settings, n_poses, n_markers);
    $display("including a long output hold and a pause until all results were in.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
